// ===== rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix digit converter
// Sizes, radix limits, word types and the status bundle of the serial divider.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Number of low bits of the input value that take part in the conversion.
  localparam int VALUE_WIDTH = 32;
  // Depth of the digit stack.
  localparam int MAX_DIGITS  = 32;

  localparam int IN_VALUE_W  = 32;
  localparam int RADIX_W     = 4;
  localparam int DIGIT_W     = 4;

  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(10);

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_radix;
  } out_word_t;

  // Status of the bit-serial divider seen by the sequencer.
  typedef struct packed {
    logic done;       // quotient and remainder are valid this cycle
    logic q_nonzero;  // the quotient has at least one bit set
  } div_status_t;

endpackage

// ===== rtl/rdc_div.sv =====
// ----------------------------------------------------------------------------
// rdc_div: bit-serial restoring divider
// Divides a VALUE_WIDTH-bit dividend by a small radix, one quotient bit per
// cycle, and reports the remainder and whether the quotient is nonzero.
// ----------------------------------------------------------------------------
module rdc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0]     dividend_i,
  input  logic [rdc_pkg::RADIX_W-1:0]         divisor_i,
  output logic [rdc_pkg::VALUE_WIDTH-1:0]     quotient_o,
  output logic [rdc_pkg::RADIX_W-1:0]         remainder_o,
  output rdc_pkg::div_status_t                status_o
);

  logic [rdc_pkg::VALUE_WIDTH-1:0] val_q, val_d;
  logic [rdc_pkg::RADIX_W-1:0]     rem_q, rem_d;
  logic [rdc_pkg::RADIX_W-1:0]     div_q;
  logic [rdc_pkg::BIT_CNT_W-1:0]   bit_q;
  logic                            run_q;
  logic                            done_q;
  logic                            qnz_q;

  logic [rdc_pkg::RADIX_W:0] trial;
  logic [rdc_pkg::RADIX_W:0] diff;
  logic                      q_bit;

  // The remainder stays below the divisor, so the trial value shifted in
  // from the dividend is always below twice the divisor.
  always_comb begin
    trial = {rem_q, val_q[rdc_pkg::VALUE_WIDTH-1]};
    diff  = trial - {1'b0, div_q};
    q_bit = (trial >= {1'b0, div_q});
    rem_d = q_bit ? diff[rdc_pkg::RADIX_W-1:0] : trial[rdc_pkg::RADIX_W-1:0];
    val_d = {val_q[rdc_pkg::VALUE_WIDTH-2:0], q_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      qnz_q  <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        run_q <= 1'b1;
        qnz_q <= 1'b0;
        bit_q <= rdc_pkg::BIT_CNT_W'(rdc_pkg::VALUE_WIDTH - 1);
      end else if (run_q) begin
        qnz_q <= qnz_q | q_bit;
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      val_q <= val_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o         = val_q;
  assign remainder_o        = rem_q;
  assign status_o.done      = done_q;
  assign status_o.q_nonzero = qnz_q;

endmodule

// ===== rtl/radix_digit_converter_unit.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_unit: unsigned integer to base 2..10 digits
// Converts a value into its digits by repeated division, most significant
// digit first, one digit word per result strobe.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. A radix outside
// 2 to 10 gives one result word with bad_radix and last set and a zero digit,
// in the cycle after the command; a zero value gives the single digit 0 the
// same way, and busy stays low in both cases. Otherwise busy rises and the
// value is divided by the radix with a bit-serial divider that retires one
// quotient bit per cycle. Remainders go onto a digit stack; when the quotient
// reaches zero the stack is popped at one digit word per cycle. Result words
// appear on res_o for exactly one cycle, marked by res_valid_o, and the
// receiver must take them as they come: there is no backpressure. The word
// with last set is the final one of a command, and busy is already low in
// that cycle.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  rdc_pkg::in_word_t  cmd_i,
  output logic               busy,
  output logic               res_valid_o,
  output rdc_pkg::out_word_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [rdc_pkg::DIG_CNT_W-1:0]   cnt_q;
  logic [rdc_pkg::RADIX_W-1:0]     radix_q;
  logic                            res_valid_q;
  logic                            res_last_q;
  logic                            res_bad_q;
  logic [rdc_pkg::DIGIT_W-1:0]     res_digit_q;

  // Digit stack, written while dividing and read while emitting.
  logic [rdc_pkg::DIGIT_W-1:0]     stack_mem [rdc_pkg::MAX_DIGITS];

  logic                            accept;
  logic                            bad_radix;
  logic                            zero_value;
  logic [rdc_pkg::VALUE_WIDTH-1:0] cmd_value;

  logic                            div_load;
  logic [rdc_pkg::VALUE_WIDTH-1:0] div_dividend;
  logic [rdc_pkg::RADIX_W-1:0]     div_divisor;
  logic [rdc_pkg::VALUE_WIDTH-1:0] div_quotient;
  logic [rdc_pkg::RADIX_W-1:0]     div_remainder;
  rdc_pkg::div_status_t            div_st;

  logic                            push;
  logic                            stack_has_room;
  logic [rdc_pkg::DIG_CNT_W-1:0]   cnt_dec;

  assign accept     = start && (state_q == ST_IDLE);
  assign cmd_value  = rdc_pkg::VALUE_WIDTH'(cmd_i.value);
  assign bad_radix  = (cmd_i.radix < rdc_pkg::RADIX_MIN) ||
                      (cmd_i.radix > rdc_pkg::RADIX_MAX);
  assign zero_value = (cmd_value == '0);

  assign stack_has_room = (cnt_q < rdc_pkg::DIG_CNT_W'(rdc_pkg::MAX_DIGITS));
  assign cnt_dec        = cnt_q - 1'b1;

  // Pushes onto a full stack are dropped, which keeps only the least
  // significant digits when a value would need more than the stack holds.
  assign push = (state_q == ST_DIV) && div_st.done && stack_has_room;

  // The divider is started by a new command and restarted on every quotient
  // that still has bits left.
  assign div_load     = (accept && !bad_radix && !zero_value) ||
                        ((state_q == ST_DIV) && div_st.done && div_st.q_nonzero);
  assign div_dividend = accept ? cmd_value : div_quotient;
  assign div_divisor  = accept ? cmd_i.radix : radix_q;

  rdc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (div_load),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder),
    .status_o    (div_st)
  );

  // Sequencer with its registered result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
      res_bad_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          res_valid_q <= 1'b0;
          if (accept) begin
            if (bad_radix) begin
              res_valid_q <= 1'b1;
              res_last_q  <= 1'b1;
              res_bad_q   <= 1'b1;
            end else if (zero_value) begin
              res_valid_q <= 1'b1;
              res_last_q  <= 1'b1;
              res_bad_q   <= 1'b0;
            end else begin
              cnt_q   <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          res_valid_q <= 1'b0;
          if (div_st.done) begin
            if (stack_has_room) begin
              cnt_q <= cnt_q + 1'b1;
            end
            if (!div_st.q_nonzero) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          res_bad_q   <= 1'b0;
          res_last_q  <= (cnt_q == rdc_pkg::DIG_CNT_W'(1));
          cnt_q       <= cnt_dec;
          if (cnt_q == rdc_pkg::DIG_CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          res_valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      radix_q <= cmd_i.radix;
    end
  end

  // Stack write and registered read. The digit is zero on the words that
  // are not popped from the stack.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[rdc_pkg::DIG_IDX_W-1:0]] <= div_remainder;
    end
    if (state_q == ST_EMIT) begin
      res_digit_q <= stack_mem[cnt_dec[rdc_pkg::DIG_IDX_W-1:0]];
    end else begin
      res_digit_q <= '0;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign res_valid_o     = res_valid_q;
  assign res_o.digit     = res_digit_q;
  assign res_o.last      = res_last_q;
  assign res_o.bad_radix = res_bad_q;

endmodule

// ===== rtl/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// rdc_checker: port-level checks for the radix digit converter
// Watches commands and result words and checks their timing and contents.
// ----------------------------------------------------------------------------
module rdc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input rdc_pkg::in_word_t  cmd_i,
  input logic               busy,
  input logic               res_valid_o,
  input rdc_pkg::out_word_t res_o
);

  logic cmd_bad;
  logic cmd_zero;

  assign cmd_bad  = (cmd_i.radix < rdc_pkg::RADIX_MIN) ||
                    (cmd_i.radix > rdc_pkg::RADIX_MAX);
  assign cmd_zero = (rdc_pkg::VALUE_WIDTH'(cmd_i.value) == '0);

  // A bad radix is answered by a single flagged word in the next cycle.
  a_bad_radix_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_bad) |=>
      (res_valid_o && res_o.last && res_o.bad_radix && (res_o.digit == '0)))
  else $error("bad radix was not answered by one flagged word");

  // A zero value is answered by the single digit zero in the next cycle.
  a_zero_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cmd_bad && cmd_zero) |=>
      (res_valid_o && res_o.last && !res_o.bad_radix && (res_o.digit == '0)))
  else $error("zero value was not answered by a single zero digit");

  // Digits are decimal digits at most.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.digit <= rdc_pkg::DIGIT_W'(9)))
  else $error("result digit out of range");

  // More words follow only while busy; the final word frees the unit.
  a_last_vs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last == !busy))
  else $error("last flag disagrees with busy");

  // An error word is always the only and final word of its command.
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_radix) |-> (res_o.last && $past(start && !busy)))
  else $error("bad radix word without a command just before it");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .cmd_i       (cmd_i),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
